>>> hw/rtl/wpm_pkg.sv
// ----------------------------------------------------------------------------
// wpm_pkg: shared types and constants for the wildcard pattern matcher
// Beat payloads, command codes and the wildcard byte values.
// ----------------------------------------------------------------------------
package wpm_pkg;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_TEXT   = 2'd2;
  localparam logic [1:0] CMD_END    = 2'd3;

  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_ANY  = 8'h3F;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] symbol;
  } wpm_in_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } wpm_out_t;

endpackage

>>> hw/rtl/wpm_scan.sv
// ----------------------------------------------------------------------------
// wpm_scan: parallel prefix carry scan
// Computes c[k] = g[k] | p[k] & c[k-1] with carry-in, in log2 levels.
// ----------------------------------------------------------------------------
module wpm_scan #(
  parameter int N = 64
) (
  input  logic [N-1:0] g,
  input  logic [N-1:0] p,
  input  logic         cin,
  output logic [N-1:0] c
);

  localparam int W      = N + 1;
  localparam int LEVELS = $clog2(W);

  logic [W-1:0] gen [LEVELS+1];
  logic [W-1:0] prop [LEVELS+1];

  always_comb begin
    gen[0]  = {g, cin};
    prop[0] = {p, 1'b0};
    for (int lvl = 0; lvl < LEVELS; lvl++) begin
      for (int k = 0; k < W; k++) begin
        if (k >= (1 << lvl)) begin
          gen[lvl+1][k]  = gen[lvl][k] | (prop[lvl][k] & gen[lvl][k - (1 << lvl)]);
          prop[lvl+1][k] = prop[lvl][k] & prop[lvl][k - (1 << lvl)];
        end else begin
          gen[lvl+1][k]  = gen[lvl][k];
          prop[lvl+1][k] = prop[lvl][k];
        end
      end
    end
  end

  assign c = gen[LEVELS][W-1:1];

endmodule

>>> hw/rtl/wpm_column.sv
// ----------------------------------------------------------------------------
// wpm_column: pattern store and match column
// Holds the pattern bytes, the prefix match bits and the overflow flag, and
// applies one command per enabled cycle.
// ----------------------------------------------------------------------------
module wpm_column #(
  parameter int PAT_MAX = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  wpm_pkg::wpm_in_t  op,
  output wpm_pkg::wpm_out_t status
);

  import wpm_pkg::*;

  localparam int LEN_W = $clog2(PAT_MAX + 1);
  localparam int IDX_W = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;

  logic [7:0]       pattern_store [PAT_MAX];
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] len_next;
  logic [LEN_W-1:0] len_inc;
  logic [PAT_MAX:0] col;
  logic [PAT_MAX:0] col_next;
  logic             ovf;
  logic             ovf_next;
  logic             full;

  logic [PAT_MAX-1:0] active;
  logic [PAT_MAX-1:0] star;
  logic [PAT_MAX-1:0] hit;
  logic [PAT_MAX-1:0] text_g;
  logic [PAT_MAX-1:0] scan_g;
  logic [PAT_MAX-1:0] scan_p;
  logic [PAT_MAX-1:0] scan_c;
  logic               rearm;

  assign full    = (len == LEN_W'(PAT_MAX));
  assign len_inc = len + LEN_W'(1);
  assign rearm   = (op.cmd == CMD_END);

  // one cell per pattern position, cell k holds pattern byte k
  always_comb begin
    for (int k = 0; k < PAT_MAX; k++) begin
      active[k] = (LEN_W'(k + 1) <= len);
      star[k]   = (pattern_store[k] == CH_STAR);
      hit[k]    = (pattern_store[k] == CH_ANY) || (pattern_store[k] == op.symbol);
      text_g[k] = active[k] & (star[k] ? col[k+1] : (hit[k] & col[k]));
    end
  end

  // text: star runs spread the match forward; rearm: prefix of all stars
  assign scan_g = rearm ? '0 : text_g;
  assign scan_p = active & star;

  wpm_scan #(
    .N(PAT_MAX)
  ) u_scan (
    .g  (scan_g),
    .p  (scan_p),
    .cin(rearm),
    .c  (scan_c)
  );

  always_comb begin
    col_next = col;
    len_next = len;
    ovf_next = ovf;
    unique case (op.cmd)
      CMD_CLEAR: begin
        len_next    = '0;
        ovf_next    = 1'b0;
        col_next    = '0;
        col_next[0] = 1'b1;
      end
      CMD_APPEND: begin
        if (full) begin
          ovf_next = 1'b1;
        end else begin
          col_next[len_inc] = col[len] & (op.symbol == CH_STAR);
          len_next          = len_inc;
        end
      end
      CMD_TEXT: begin
        col_next = {scan_c, 1'b0};
      end
      CMD_END: begin
        col_next = {scan_c, 1'b1};
      end
      default: begin
        col_next = col;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      ovf <= 1'b0;
      col <= {{PAT_MAX{1'b0}}, 1'b1};
    end else if (en) begin
      len <= len_next;
      ovf <= ovf_next;
      col <= col_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en && (op.cmd == CMD_APPEND) && !full) begin
      pattern_store[len[IDX_W-1:0]] <= op.symbol;
    end
  end

  assign status.matched          = col[len];
  assign status.pattern_overflow = ovf;

endmodule

>>> hw/rtl/wildcard_pattern_matcher.sv
// Throughput: one beat per cycle unless stalled; the whole column update for
// a text byte, including the prefix scan across star runs, fits between two
// registers. Only an end-of-text beat behind an unaccepted result stalls the
// input. An end-of-text result comes via the input and result registers.
// Reset (synchronous): empty pattern, overflow clear, column at bit 0 only.
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher: streaming whole-text wildcard matcher
// Input register, column update, and a result register for end-of-text beats.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher #(
  parameter int PAT_MAX = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  wpm_pkg::wpm_in_t  item,
  output logic              result_valid,
  input  logic              result_stall,
  output wpm_pkg::wpm_out_t result
);

  import wpm_pkg::*;

  logic      s1_valid;
  wpm_in_t   s1;
  logic      end_now;
  logic      advance;
  logic      fire;
  wpm_out_t  status;

  assign end_now    = s1_valid && (s1.cmd == CMD_END);
  // an end beat waits only while the previous result is still held
  assign advance    = !(end_now && result_valid && result_stall);
  assign item_stall = s1_valid && !advance;
  assign fire       = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      s1 <= item;
    end
  end

  wpm_column #(
    .PAT_MAX(PAT_MAX)
  ) u_column (
    .clk   (clk),
    .rst   (rst),
    .en    (fire),
    .op    (s1),
    .status(status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire && end_now) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && end_now) begin
      result <= status;
    end
  end

endmodule
